[sv/utw_pkg.sv]
// Shared types, constants and helper functions of the UTF-8 to wide transcoder.
package utw_pkg;

    // Lead byte thresholds that set the sequence length
    localparam logic [7:0] LEAD_LEN2 = 8'd192;
    localparam logic [7:0] LEAD_LEN3 = 8'd224;
    localparam logic [7:0] LEAD_LEN4 = 8'd240;
    localparam logic [7:0] LEAD_LEN5 = 8'd248;
    localparam logic [7:0] LEAD_LEN6 = 8'd252;

    localparam logic [31:0] CODE_MAX    = 32'h0010_FFFF;
    // Bits 31:11 of any code point from D800 to DFFF
    localparam logic [20:0] SURR_BLOCK  = 21'(32'hD800 >> 11);
    // High surrogate: ((cp - 0x10000) >> 10) + 0xD800 == cp[20:10] + 0xD7C0
    localparam logic [15:0] HI_SURR_BIAS = 16'hD7C0;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // Register indexes of the configuration port
    localparam logic REG_WIDE_IS_32 = 1'b0;
    localparam logic REG_REPL_CODE  = 1'b1;

    // One finished or cut-off character handed from front to back
    typedef struct packed {
        logic [31:0] acc;       // bytes accumulated as acc*64 + byte, mod 2^32
        logic [2:0]  len_idx;   // sequence length minus one
        logic        trunc;     // string ended inside the sequence
        logic        last;      // last byte of the string
    } t_q_item;

    typedef struct packed {
        logic        wide_is_32;
        logic [15:0] repl_code;
    } t_cfg;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < LEAD_LEN2) len = 3'd1;
        else if (b < LEAD_LEN3) len = 3'd2;
        else if (b < LEAD_LEN4) len = 3'd3;
        else if (b < LEAD_LEN5) len = 3'd4;
        else if (b < LEAD_LEN6) len = 3'd5;
        else len = 3'd6;
        return len;
    endfunction

    // Marker bits left in the sum by a sequence of length idx+1
    function automatic logic [31:0] len_offset(input logic [2:0] idx);
        logic [31:0] off;
        unique case (idx)
            3'd0: off = 32'h0000_0000;
            3'd1: off = 32'h0000_3080;
            3'd2: off = 32'h000E_2080;
            3'd3: off = 32'h03C8_2080;
            3'd4: off = 32'hFA08_2080;
            3'd5: off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

[sv/utf8_to_wide_transcoder.sv]
// UTF-8 to UTF-16 / UTF-32 transcoder top level with APB configuration port.
//
// Feed one UTF-8 byte per beat on s_axis (tdata[7:0] = byte, tlast = last
// byte of the string); the block takes a byte on every clock while its
// internal queue has room. Results leave on m_axis: tdata carries a UTF-16
// unit in the low 16 bits (upper bits zero) or, with wide_is_32 set, the
// raw 32-bit code point; tuser is high on the final unit of a character and
// tlast is high on the unit that closes the string. A character yields one
// unit, or two (a surrogate pair) for code points above 0xFFFF in 16-bit
// mode. Continuation bytes are not checked; a string that ends inside a
// sequence gives one replacement unit, as does an out-of-range or surrogate
// code point in 16-bit mode. Rate: one byte in per clock while the queue
// has room and one unit out per clock while m_axis_tready is high, set by
// the output register; the back end takes no new character while the low
// half of a pair waits. A character passes the queue, the offset subtract
// register and the output register. Write registers only while the block
// is idle: 0x0 wide_is_32 (bit 0), 0x4 replacement_code (bits 15:0).
module utf8_to_wide_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // string_last
    // unit output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] out_unit
    output logic        m_axis_tlast,   // string_end
    output logic        m_axis_tuser,   // run_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import utw_pkg::*;

    t_cfg     r_cfg;
    t_q_item  push_item;
    t_q_item  head_item;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;
    logic     cfg_wr;
    logic     reg_sel;

    // Registers sit on word addresses; paddr[2] picks the register
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_WIDE_IS_32: r_cfg.wide_is_32 <= pwdata[0];
                REG_REPL_CODE:  r_cfg.repl_code  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_WIDE_IS_32: prdata = {31'd0, r_cfg.wide_is_32};
            REG_REPL_CODE:  prdata = {16'd0, r_cfg.repl_code};
            default:        prdata = '0;
        endcase
    end

    // Front: track sequences and accumulate bytes
    utw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (q_push),
        .o_item   (push_item)
    );

    // Queue: decouple byte intake from unit output
    utw_fifo #(
        .WIDTH ($bits(t_q_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_item)
    );

    // Back: finish the code point and emit units
    utw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_item     (head_item),
        .o_q_pop      (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_unit       (m_axis_tdata),
        .o_run_last   (m_axis_tuser),
        .o_string_end (m_axis_tlast)
    );

endmodule

[sv/utw_fifo.sv]
// Small register queue between the byte front end and the unit back end.
module utw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("utw_fifo: push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("utw_fifo: pop from empty queue");

endmodule

[sv/utw_front.sv]
// Byte front end: sequence tracking and accumulation, one byte per clock while the queue is not full.
module utw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output utw_pkg::t_q_item o_item
);
    import utw_pkg::*;

    logic [2:0]  r_left, n_left;
    logic [2:0]  r_seql, n_seql;
    logic [31:0] r_acc, n_acc;
    logic        accept;
    logic        done;

    // Stall on a full queue only; a byte always fits once a slot is free
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_left == 3'd0) begin
            n_seql = lead_length(i_byte);
            n_acc  = {24'd0, i_byte};
            n_left = n_seql - 3'd1;
        end else begin
            n_seql = r_seql;
            n_acc  = {r_acc[25:0], 6'd0} + {24'd0, i_byte};
            n_left = r_left - 3'd1;
        end
        done = (n_left == 3'd0);
    end

    assign o_push         = accept && (done || i_last);
    assign o_item.acc     = n_acc;
    assign o_item.len_idx = n_seql - 3'd1;
    assign o_item.trunc   = !done;
    assign o_item.last    = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_seql <= '0;
            r_acc  <= '0;
        end else if (accept) begin
            if (done || i_last) begin
                r_left <= '0;
                r_seql <= '0;
                r_acc  <= '0;
            end else begin
                r_left <= n_left;
                r_seql <= n_seql;
                r_acc  <= n_acc;
            end
        end
    end

    a_left_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 3'd0) |-> (r_left < r_seql && r_seql <= 3'd6))
        else $error("utw_front: bytes left outside sequence length");
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_left == 3'd0 && r_acc == 32'd0))
        else $error("utw_front: state not cleared at string end");

endmodule

[sv/utw_back.sv]
// Unit back end: offset removal, UTF-16 split and the output register.
module utw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  utw_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  utw_pkg::t_q_item i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_unit,
    output logic             o_run_last,
    output logic             o_string_end
);
    import utw_pkg::*;

    // Stage 1: code point after offset removal
    logic        r_s1_valid;
    logic [31:0] r_cp;
    logic        r_trunc;
    logic        r_last;

    // Output register and the pending low surrogate
    logic        r_ovalid;
    logic [31:0] r_ounit;
    logic        r_orl;
    logic        r_oend;
    logic        r_pend;
    logic [15:0] r_pend_unit;
    logic        r_pend_end;

    logic        out_free;
    logic        s1_take;
    logic        s1_ready;
    logic [31:0] n_unit;
    logic        n_rl;
    logic        n_end;
    logic        is_pair;
    logic        bad_cp;

    assign out_free = !r_ovalid || i_ready;
    assign s1_take  = out_free && !r_pend && r_s1_valid;
    assign s1_ready = !r_s1_valid || s1_take;
    assign o_q_pop  = i_q_valid && s1_ready;

    assign bad_cp = (r_cp > CODE_MAX) || (r_cp[31:11] == SURR_BLOCK);

    always_comb begin
        is_pair = 1'b0;
        n_rl    = 1'b1;
        n_end   = r_last;
        n_unit  = r_cp;
        if (r_trunc) begin
            n_unit = {16'd0, i_cfg.repl_code};
            n_end  = 1'b1;
        end else if (i_cfg.wide_is_32) begin
            n_unit = r_cp;
        end else if (bad_cp) begin
            n_unit = {16'd0, i_cfg.repl_code};
        end else if (r_cp[31:16] != 16'd0) begin
            is_pair = 1'b1;
            n_unit  = {16'd0, HI_SURR_BIAS + {5'd0, r_cp[20:10]}};
            n_rl    = 1'b0;
            n_end   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_free) begin
                if (r_pend) begin
                    r_ovalid <= 1'b1;
                    r_pend   <= 1'b0;
                end else begin
                    r_ovalid <= r_s1_valid;
                    r_pend   <= r_s1_valid && is_pair;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cp    <= i_q_item.acc - len_offset(i_q_item.len_idx);
            r_trunc <= i_q_item.trunc;
            r_last  <= i_q_item.last;
        end
        if (out_free) begin
            if (r_pend) begin
                r_ounit <= {16'd0, r_pend_unit};
                r_orl   <= 1'b1;
                r_oend  <= r_pend_end;
            end else if (r_s1_valid) begin
                r_ounit     <= n_unit;
                r_orl       <= n_rl;
                r_oend      <= n_end;
                r_pend_unit <= LO_SURR_BASE | {6'd0, r_cp[9:0]};
                r_pend_end  <= r_last;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_unit       = r_ounit;
    assign o_run_last   = r_orl;
    assign o_string_end = r_oend;

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_ovalid)
        else $error("utw_back: low surrogate pending without a high unit");
    a_high_has_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_orl) |-> r_pend)
        else $error("utw_back: high surrogate without its low half");
    a_end_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> r_orl)
        else $error("utw_back: string end on a unit that is not a run end");

endmodule
